FILE: hdl/sptc_pkg.sv
`default_nettype none
package sptc_pkg;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam int unsigned KELVIN_OFFSET = 27315;
  localparam int unsigned F_OFFSET = 3200;
  localparam int unsigned DIV5_SHIFT = 22;
  localparam int unsigned DIV5_RECIP = ((1 << DIV5_SHIFT) + 4) / 5;
  localparam int unsigned RECIP_W = $clog2(DIV5_RECIP + 1);
  localparam int unsigned RAW_W = 15;
  localparam int unsigned CEL_W = 17;
  localparam int unsigned MAG_W = 16;
  localparam int unsigned MAG9_W = 19;
  localparam int unsigned QUOT_W = 17;
  localparam int unsigned TEMP_W = 18;
  localparam int unsigned ADDR_W = 7;
  localparam int unsigned CFG_DATA_W = 7;

  typedef enum logic [1:0] {
    UNIT_RAW        = 2'd0,
    UNIT_KELVIN     = 2'd1,
    UNIT_CELSIUS    = 2'd2,
    UNIT_FAHRENHEIT = 2'd3
  } unit_t;

  typedef enum logic {
    REG_DEVICE_ADDRESS   = 1'b0,
    REG_TEMPERATURE_UNIT = 1'b1
  } reg_idx_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] d;
    d = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      d = d[7] ? ({d[6:0], 1'b0} ^ CRC_POLY) : {d[6:0], 1'b0};
    end
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/sptc_temp_pipe.sv
`default_nettype none
module sptc_temp_pipe
  import sptc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic [RAW_W-1:0]         raw,
  input  wire unit_t                    unit,
  output logic signed [TEMP_W-1:0]      temperature
);

  logic [RAW_W-1:0]         t2_raw_r, t3_raw_r, t4_raw_r;
  logic signed [CEL_W-1:0]  t2_cel_r, t3_cel_r, t4_cel_r;
  logic [MAG9_W-1:0]        t3_mag9_r;
  logic                     t3_neg_r, t4_neg_r;
  logic [QUOT_W-1:0]        t4_quot_r;
  logic signed [TEMP_W-1:0] t5_temp_r;

  logic signed [CEL_W-1:0]          cel_nxt;
  logic [CEL_W-1:0]                 cel_abs;
  logic [MAG_W-1:0]                 mag;
  logic [MAG9_W-1:0]                mag9_nxt;
  logic [MAG9_W+RECIP_W-1:0]        prod;
  logic [QUOT_W-1:0]                quot_nxt;
  logic signed [TEMP_W-1:0]         fahr;
  logic signed [TEMP_W-1:0]         t5_nxt;

  assign cel_nxt = $signed({1'b0, raw, 1'b0}) - $signed(CEL_W'(KELVIN_OFFSET));

  assign cel_abs  = t2_cel_r[CEL_W-1] ? (~t2_cel_r + 1'b1) : t2_cel_r;
  assign mag      = cel_abs[MAG_W-1:0];
  assign mag9_nxt = {mag, 3'b000} + MAG9_W'(mag);

  assign prod     = MAG9_W'(t3_mag9_r) * RECIP_W'(DIV5_RECIP);
  assign quot_nxt = prod[DIV5_SHIFT +: QUOT_W];

  assign fahr = (t4_neg_r ? -$signed({1'b0, t4_quot_r}) : $signed({1'b0, t4_quot_r}))
                + $signed(TEMP_W'(F_OFFSET));

  always_comb begin
    case (unit)
      UNIT_RAW:        t5_nxt = $signed({{(TEMP_W-RAW_W){1'b0}}, t4_raw_r});
      UNIT_KELVIN:     t5_nxt = $signed({{(TEMP_W-RAW_W-1){1'b0}}, t4_raw_r, 1'b0});
      UNIT_CELSIUS:    t5_nxt = TEMP_W'(t4_cel_r);
      UNIT_FAHRENHEIT: t5_nxt = fahr;
      default:         t5_nxt = TEMP_W'(t4_cel_r);
    endcase
  end

  always_ff @(posedge clk) begin
    t2_raw_r  <= raw;
    t2_cel_r  <= cel_nxt;
    t3_raw_r  <= t2_raw_r;
    t3_cel_r  <= t2_cel_r;
    t3_neg_r  <= t2_cel_r[CEL_W-1];
    t3_mag9_r <= mag9_nxt;
    t4_raw_r  <= t3_raw_r;
    t4_cel_r  <= t3_cel_r;
    t4_neg_r  <= t3_neg_r;
    t4_quot_r <= quot_nxt;
    t5_temp_r <= t5_nxt;
  end

  assign temperature = t5_temp_r;

endmodule
`default_nettype wire

FILE: hdl/smbus_word_pec_check_and_temp_convert.sv
// SMBus read-word reply checker and temperature converter.
// Input: pulse start with in_command_code, in_low_byte, in_high_byte and
// in_pec_byte; a reply is taken at every edge where start is high and busy
// is low. busy stays low, so one reply can be taken in every cycle.
// Output: out_strobe marks one cycle that carries out_word_value, out_pec_ok
// (CRC-8, poly 0x07, over write address, command, read address, low and high
// byte), out_error_flag (word bit 15) and out_temperature (raw, centikelvin,
// centidegrees C or F, per the unit register).
// Throughput is one reply per cycle, set by the five-stage pipeline whose
// deepest stage holds a 19x20 reciprocal multiply for the divide by 5 of the
// Fahrenheit path.
// Configuration: cfg_we with cfg_index 0 (device address) or 1 (unit) and
// cfg_data; write only while no reply is in flight.
// Reset: synchronous, active low; clears the pipeline valid bits, sets the
// address to 0 and the unit to Celsius. Results cannot be held off: the
// receiver must take each one in its strobe cycle.
`default_nettype none
module smbus_word_pec_check_and_temp_convert
  import sptc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [7:0]               in_command_code,
  input  wire logic [7:0]               in_low_byte,
  input  wire logic [7:0]               in_high_byte,
  input  wire logic [7:0]               in_pec_byte,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  output logic                          out_strobe,
  output logic [15:0]                   out_word_value,
  output logic                          out_pec_ok,
  output logic                          out_error_flag,
  output logic signed [TEMP_W-1:0]      out_temperature
);

  logic [ADDR_W-1:0] dev_addr_r;
  unit_t             unit_r;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [7:0] s1_lo_r, s1_hi_r, s1_pec_r, s1_crc_r;
  logic [7:0] s2_lo_r, s2_hi_r, s2_pec_r, s2_crc_r;
  logic [15:0] s3_word_r, s4_word_r, s5_word_r;
  logic s3_ok_r, s4_ok_r, s5_ok_r;

  logic       accept;
  logic [7:0] waddr, raddr;
  logic [7:0] crc1_nxt, crc2_nxt, crc3_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign waddr  = {dev_addr_r, 1'b0};
  assign raddr  = {dev_addr_r, 1'b1};

  assign crc1_nxt = crc8_byte(crc8_byte(8'h00, waddr), in_command_code);
  assign crc2_nxt = crc8_byte(crc8_byte(s1_crc_r, raddr), s1_lo_r);
  assign crc3_nxt = crc8_byte(s2_crc_r, s2_hi_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= '0;
      unit_r     <= UNIT_CELSIUS;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DEVICE_ADDRESS:   dev_addr_r <= cfg_data[ADDR_W-1:0];
        REG_TEMPERATURE_UNIT: unit_r     <= unit_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_lo_r   <= in_low_byte;
    s1_hi_r   <= in_high_byte;
    s1_pec_r  <= in_pec_byte;
    s1_crc_r  <= crc1_nxt;
    s2_lo_r   <= s1_lo_r;
    s2_hi_r   <= s1_hi_r;
    s2_pec_r  <= s1_pec_r;
    s2_crc_r  <= crc2_nxt;
    s3_word_r <= {s2_hi_r, s2_lo_r};
    s3_ok_r   <= (crc3_nxt == s2_pec_r);
    s4_word_r <= s3_word_r;
    s4_ok_r   <= s3_ok_r;
    s5_word_r <= s4_word_r;
    s5_ok_r   <= s4_ok_r;
  end

  sptc_temp_pipe u_temp (
    .clk         (clk),
    .raw         ({s1_hi_r[6:0], s1_lo_r}),
    .unit        (unit_r),
    .temperature (out_temperature)
  );

  assign out_strobe     = v5_r;
  assign out_word_value = s5_word_r;
  assign out_pec_ok     = s5_ok_r;
  assign out_error_flag = s5_word_r[15];

endmodule
`default_nettype wire

FILE: hdl/sptc_checker.sv
`default_nettype none
module sptc_checker
  import sptc_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     out_strobe,
  input wire logic [15:0]              out_word_value,
  input wire logic                     out_error_flag,
  input wire logic signed [TEMP_W-1:0] out_temperature
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_strobe)
    else $error("transfer accepted without a result five cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 5))
    else $error("result without a matching input transfer");

  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_error_flag == out_word_value[15]))
    else $error("error flag differs from word bit 15");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_temperature >= -18'sd45967 && out_temperature <= 18'sd71994))
    else $error("temperature out of range");

endmodule

bind smbus_word_pec_check_and_temp_convert sptc_checker u_sptc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_word_value  (out_word_value),
  .out_error_flag  (out_error_flag),
  .out_temperature (out_temperature)
);
`default_nettype wire

FILE: tb/sv/smbus_word_pec_check_and_temp_convert_checker.sv
`default_nettype none
module smbus_word_pec_check_and_temp_convert_checker
  import sptc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic                     busy,
  input  wire logic [7:0]               in_command_code,
  input  wire logic [7:0]               in_low_byte,
  input  wire logic [7:0]               in_high_byte,
  input  wire logic [7:0]               in_pec_byte,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                     out_strobe,
  input  wire logic [15:0]              out_word_value,
  input  wire logic                     out_pec_ok,
  input  wire logic                     out_error_flag,
  input  wire logic signed [TEMP_W-1:0] out_temperature,
  output int                            fail_count,
  output int                            replies_owed
);

  typedef struct packed {
    logic [15:0]              word_value;
    logic                     pec_ok;
    logic                     error_flag;
    logic signed [TEMP_W-1:0] temperature;
  } sensor_reply_t;

  logic [ADDR_W-1:0] sensor_addr;
  unit_t             temp_unit;
  sensor_reply_t     pending_replies[$];

  initial begin
    fail_count   = 0;
    replies_owed = 0;
    sensor_addr  = '0;
    temp_unit    = UNIT_CELSIUS;
  end

  function automatic logic [7:0] smbus_pec(input logic [ADDR_W-1:0] addr,
                                           input logic [7:0] cmd,
                                           input logic [7:0] lo,
                                           input logic [7:0] hi);
    logic [39:0] frame;
    logic [7:0]  crc;
    logic        feedback;
    frame = {addr, 1'b0, cmd, addr, 1'b1, lo, hi};
    crc   = 8'h00;
    for (int i = 39; i >= 0; i--) begin
      feedback = crc[7] ^ frame[i];
      crc      = {crc[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
    end
    return crc;
  endfunction

  function automatic sensor_reply_t decode_reply(input logic [7:0] cmd,
                                                 input logic [7:0] lo,
                                                 input logic [7:0] hi,
                                                 input logic [7:0] pec);
    sensor_reply_t reply;
    int            raw;
    int            centi_c;
    int            temp;
    reply.word_value = {hi, lo};
    reply.pec_ok     = (smbus_pec(sensor_addr, cmd, lo, hi) == pec);
    reply.error_flag = hi[7];
    raw              = int'({hi[6:0], lo});
    centi_c          = 2 * raw - int'(KELVIN_OFFSET);
    case (temp_unit)
      UNIT_RAW: begin
        temp = raw;
      end
      UNIT_KELVIN: begin
        temp = 2 * raw;
      end
      UNIT_CELSIUS: begin
        temp = centi_c;
      end
      default: begin
        temp = (centi_c * 9) / 5 + int'(F_OFFSET);
      end
    endcase
    reply.temperature = temp[TEMP_W-1:0];
    return reply;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    sensor_reply_t want;
    if (!rst_n) begin
      sensor_addr = '0;
      temp_unit   = UNIT_CELSIUS;
      pending_replies.delete();
    end else begin
      if (out_strobe) begin
        if (pending_replies.size() == 0) begin
          report("reply with none pending, word", out_word_value, 0);
        end else begin
          want = pending_replies.pop_front();
          if (out_word_value !== want.word_value)
            report("word_value", out_word_value, want.word_value);
          if (out_pec_ok !== want.pec_ok)
            report("pec_ok", out_pec_ok, want.pec_ok);
          if (out_error_flag !== want.error_flag)
            report("error_flag", out_error_flag, want.error_flag);
          if (out_temperature !== want.temperature)
            report("temperature", out_temperature, want.temperature);
        end
      end
      if (start && !busy)
        pending_replies.push_back(decode_reply(in_command_code, in_low_byte,
                                               in_high_byte, in_pec_byte));
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_DEVICE_ADDRESS: begin
            sensor_addr = cfg_data[ADDR_W-1:0];
          end
          REG_TEMPERATURE_UNIT: begin
            temp_unit = unit_t'(cfg_data[1:0]);
          end
          default: begin
          end
        endcase
      end
    end
    replies_owed = pending_replies.size();
  end

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none
module tb;
  import sptc_pkg::*;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [7:0]               in_command_code;
  logic [7:0]               in_low_byte;
  logic [7:0]               in_high_byte;
  logic [7:0]               in_pec_byte;
  logic                     cfg_we;
  logic                     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     out_strobe;
  logic [15:0]              out_word_value;
  logic                     out_pec_ok;
  logic                     out_error_flag;
  logic signed [TEMP_W-1:0] out_temperature;
  int                       fail_count;
  int                       replies_owed;

  logic              transfer_taken;
  logic [ADDR_W-1:0] stim_addr;
  bit                steady_sender;

  smbus_word_pec_check_and_temp_convert DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command_code (in_command_code),
    .in_low_byte     (in_low_byte),
    .in_high_byte    (in_high_byte),
    .in_pec_byte     (in_pec_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_strobe      (out_strobe),
    .out_word_value  (out_word_value),
    .out_pec_ok      (out_pec_ok),
    .out_error_flag  (out_error_flag),
    .out_temperature (out_temperature)
  );

  smbus_word_pec_check_and_temp_convert_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command_code (in_command_code),
    .in_low_byte     (in_low_byte),
    .in_high_byte    (in_high_byte),
    .in_pec_byte     (in_pec_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_strobe      (out_strobe),
    .out_word_value  (out_word_value),
    .out_pec_ok      (out_pec_ok),
    .out_error_flag  (out_error_flag),
    .out_temperature (out_temperature),
    .fail_count      (fail_count),
    .replies_owed    (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    transfer_taken <= rst_n && start && !busy;
  end

  initial begin
    #2000000;
    $display("smbus_word_pec_check_and_temp_convert verification failed");
    $finish;
  end

  function automatic logic [7:0] good_pec(input logic [7:0] cmd, input logic [7:0] lo,
                                          input logic [7:0] hi);
    logic [39:0] frame;
    logic [7:0]  crc;
    frame = {stim_addr, 1'b0, cmd, stim_addr, 1'b1, lo, hi};
    crc   = 8'h00;
    for (int i = 39; i >= 0; i--) begin
      crc = {crc[6:0], 1'b0} ^ ((crc[7] ^ frame[i]) ? CRC_POLY : 8'h00);
    end
    return crc;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic send_reply(input logic [7:0] cmd, input logic [7:0] lo,
                            input logic [7:0] hi, input logic [7:0] pec);
    start           <= 1'b1;
    in_command_code <= cmd;
    in_low_byte     <= lo;
    in_high_byte    <= hi;
    in_pec_byte     <= pec;
    do @(negedge clk); while (!transfer_taken);
  endtask

  task automatic send_checked(input logic [7:0] cmd, input logic [7:0] lo,
                              input logic [7:0] hi, input bit corrupt);
    logic [7:0] pec;
    pec = good_pec(cmd, lo, hi);
    if (corrupt)
      pec = ($urandom_range(0, 1) == 0) ? pec ^ (8'h01 << $urandom_range(0, 7))
                                         : 8'($urandom());
    while (!steady_sender && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      @(negedge clk);
    end
    send_reply(cmd, lo, hi, pec);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (replies_owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    if (idx == REG_DEVICE_ADDRESS)
      stim_addr = value[ADDR_W-1:0];
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] unit_word;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_command_code = '0;
    in_low_byte     = '0;
    in_high_byte    = '0;
    in_pec_byte     = '0;
    cfg_we          = 1'b0;
    cfg_index       = REG_DEVICE_ADDRESS;
    cfg_data        = '0;
    stim_addr       = '0;
    steady_sender   = 1'b1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: address 0, Celsius
    send_checked(8'h07, 8'h00, 8'h00, 1'b0);
    send_checked(8'h07, 8'hFF, 8'hFF, 1'b0);
    send_checked(8'h00, 8'h00, 8'h80, 1'b0);
    send_checked(8'hFF, 8'hFF, 8'h7F, 1'b0);
    send_reply(8'h07, 8'h3B, 8'h3A, 8'h00);
    send_reply(8'h06, 8'h3B, 8'h3A, 8'hFF);
    drain();

    // wide values: upper data bits must be dropped
    write_reg(REG_DEVICE_ADDRESS, 7'h7F);
    write_reg(REG_TEMPERATURE_UNIT, 7'h7F);
    send_checked(8'h07, 8'h00, 8'h00, 1'b0);
    send_checked(8'h07, 8'h01, 8'h00, 1'b0);
    send_checked(8'h07, 8'hFF, 8'hFF, 1'b0);
    send_checked(8'h07, 8'h55, 8'h2A, 1'b1);
    drain();

    write_reg(REG_TEMPERATURE_UNIT, 7'h7C);
    send_checked(8'h07, 8'h00, 8'h00, 1'b0);
    send_checked(8'h07, 8'hFF, 8'h7F, 1'b0);
    send_checked(8'hA5, 8'h5A, 8'hC3, 1'b1);
    drain();

    write_reg(REG_TEMPERATURE_UNIT, 7'h01);
    send_checked(8'h07, 8'h00, 8'h80, 1'b0);
    send_checked(8'h07, 8'hFF, 8'h7F, 1'b0);
    send_checked(8'h24, 8'h12, 8'h34, 1'b0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_reg(REG_DEVICE_ADDRESS, 7'h00);
        1: write_reg(REG_DEVICE_ADDRESS, 7'h7F);
        default: write_reg(REG_DEVICE_ADDRESS, 7'($urandom()));
      endcase
      unit_word = 7'($urandom());
      unit_word[1:0] = 2'(phase);
      write_reg(REG_TEMPERATURE_UNIT, unit_word);
      steady_sender = (phase == 2);
      for (int n = 0; n < 64; n++) begin
        send_checked(($urandom_range(0, 3) == 0) ? 8'h07 : pick_byte(),
                     pick_byte(), pick_byte(), $urandom_range(0, 99) < 15);
      end
      drain();
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("smbus_word_pec_check_and_temp_convert verification clean");
    end else begin
      $display("smbus_word_pec_check_and_temp_convert verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
hdl/sptc_pkg.sv
hdl/sptc_temp_pipe.sv
hdl/smbus_word_pec_check_and_temp_convert.sv
hdl/sptc_checker.sv
tb/sv/smbus_word_pec_check_and_temp_convert_checker.sv
tb/sv/tb.sv
